/* design/cdsd_pkg.sv */
// Package for the countdown seven-segment driver: digit codes, request payload
// types, segment table and LED bar decode. No dependencies.
package cdsd_pkg;

   localparam logic [3:0] CODE_DASH   = 4'd10;
   localparam logic [3:0] CODE_P      = 4'd11;
   localparam logic [3:0] CODE_O      = 4'd12;
   localparam logic [3:0] CODE_U      = 4'd13;
   localparam logic [3:0] CODE_R      = 4'd14;
   localparam logic [3:0] CODE_UNUSED = 4'd15;

   localparam logic [13:0] TIME_POUR = 14'h3FFE;   // -2 in 14 bits

   localparam int unsigned DIGITS = 4;

   // Minutes/seconds split of one request, handed to the frame sequencer.
   typedef struct packed {
      logic       neg;
      logic       pour;
      logic [7:0] mins;
      logic [5:0] secs;
      logic [5:0] bar;
   } split_type;

   // Active-low segments, bit6 = a .. bit0 = g.
   function automatic logic [6:0] seg_lookup(input logic [3:0] code);
      logic [6:0] seg;
      unique case (code)
         4'd0:        seg = 7'b1111110 ^ 7'h7F;
         4'd1:        seg = 7'b0110000 ^ 7'h7F;
         4'd2:        seg = 7'b1101101 ^ 7'h7F;
         4'd3:        seg = 7'b1111001 ^ 7'h7F;
         4'd4:        seg = 7'b0110011 ^ 7'h7F;
         4'd5:        seg = 7'b1011011 ^ 7'h7F;
         4'd6:        seg = 7'b1011111 ^ 7'h7F;
         4'd7:        seg = 7'b1110000 ^ 7'h7F;
         4'd8:        seg = 7'b1111111 ^ 7'h7F;
         4'd9:        seg = 7'b1111011 ^ 7'h7F;
         CODE_DASH:   seg = 7'b0000001 ^ 7'h7F;
         CODE_P:      seg = 7'b1100111 ^ 7'h7F;
         CODE_O:      seg = 7'b1111110 ^ 7'h7F;
         CODE_U:      seg = 7'b0111110 ^ 7'h7F;
         CODE_R:      seg = 7'b1100110 ^ 7'h7F;
         CODE_UNUSED: seg = 7'b1111111 ^ 7'h7F;
      endcase
      return seg;
   endfunction

   // Thermometer bar: value/10 LEDs lit for quotients 1..6, else dark.
   // value*205 >> 11 is exact for value/10 below 1029.
   function automatic logic [5:0] bar_code(input logic [7:0] value);
      logic [15:0] prod;
      logic [4:0]  quot;
      logic [5:0]  bar;
      prod = {8'd0, value} * 16'd205;
      quot = prod[15:11];
      if (quot >= 5'd1 && quot <= 5'd6) begin
         bar = 6'((7'd1 << quot[2:0]) - 7'd1);
      end else begin
         bar = 6'd0;
      end
      return bar;
   endfunction

endpackage

/* design/cdsd_split.sv */
// Input register and minutes/seconds split stage.
// Depends on cdsd_pkg (split_type, bar_code, TIME_POUR).
module cdsd_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [13:0]  req_time_seconds,
   input  logic        [7:0]   req_duration_value,
   output logic                split_valid,
   output cdsd_pkg::split_type split_data,
   input  logic                split_take
);

   logic                a_valid_ff, a_valid_in;
   logic [13:0]         a_time_ff;
   logic [7:0]          a_dur_ff;
   logic                b_valid_ff, b_valid_in;
   cdsd_pkg::split_type b_data_ff, b_data_in;

   logic        b_free;
   logic        a_load;
   logic [12:0] raw;
   logic [27:0] min_prod;
   logic [7:0]  mins;
   logic [13:0] mins60;
   logic [12:0] sec_full;

   assign b_free    = !b_valid_ff || split_take;
   assign req_stall = a_valid_ff && !b_free;
   assign a_load    = req_valid && !req_stall;

   assign a_valid_in = a_load || (a_valid_ff && !b_free);
   assign b_valid_in = b_free ? a_valid_ff : b_valid_ff;

   // mins = raw/60 via reciprocal 17477/2^20, exact for raw below 8192
   always_comb begin
      raw      = a_time_ff[12:0];
      min_prod = {15'd0, raw} * 28'd17477;
      mins     = min_prod[27:20];
      mins60   = {mins, 6'd0} - {4'd0, mins, 2'd0};
      sec_full = raw - mins60[12:0];

      b_data_in.neg  = a_time_ff[13];
      b_data_in.pour = (a_time_ff == cdsd_pkg::TIME_POUR);
      b_data_in.mins = mins;
      b_data_in.secs = sec_full[5:0];
      b_data_in.bar  = cdsd_pkg::bar_code(a_dur_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      if (a_load) begin
         a_time_ff <= req_time_seconds;
         a_dur_ff  <= req_duration_value;
      end
      if (b_free && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign split_valid = b_valid_ff;
   assign split_data  = b_data_ff;

endmodule

/* design/cdsd_frame.sv */
// Digit decode, four-frame sequencer and result register.
// Depends on cdsd_pkg (split_type, digit codes, seg_lookup).
module cdsd_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                split_valid,
   input  cdsd_pkg::split_type split_data,
   output logic                split_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_digit_enable,
   output logic [6:0]          rsp_segment_pattern,
   output logic                rsp_decimal_point,
   output logic [5:0]          rsp_led_bar,
   output logic                rsp_last_frame
);

   logic       c_valid_ff, c_valid_in;
   logic [1:0] c_idx_ff, c_idx_in;
   logic [3:0] c_code_ff [cdsd_pkg::DIGITS];
   logic [5:0] c_bar_ff;

   logic       o_valid_ff, o_valid_in;
   logic [3:0] o_enable_ff;
   logic [6:0] o_seg_ff;
   logic       o_dp_ff;
   logic [5:0] o_bar_ff;
   logic       o_last_ff;

   logic       out_free, c_fire, c_done, c_free;
   logic [3:0] code_in [cdsd_pkg::DIGITS];
   logic [15:0] mt_prod;
   logic [4:0]  mt;
   logic [7:0]  mu_full;
   logic [13:0] st_prod;
   logic [2:0]  st;
   logic [5:0]  su_full;
   logic [4:0]  mt_mod;

   assign out_free   = !o_valid_ff || !rsp_stall;
   assign c_fire     = c_valid_ff && out_free;
   assign c_done     = c_fire && (c_idx_ff == 2'd3);
   assign c_free     = !c_valid_ff || c_done;
   assign split_take = split_valid && c_free;

   // decimal digits; x*205 >> 11 gives x/10 for these small values
   always_comb begin
      mt_prod = {8'd0, split_data.mins} * 16'd205;
      mt      = mt_prod[15:11];
      mu_full = split_data.mins - {mt, 3'd0} - {2'd0, mt, 1'd0};
      mt_mod  = (mt >= 5'd10) ? (mt - 5'd10) : mt;   // minutes wrap at 100
      st_prod = {8'd0, split_data.secs} * 14'd205;
      st      = st_prod[13:11];
      su_full = split_data.secs - {st, 3'd0} - {2'd0, st, 1'd0};

      if (split_data.pour) begin
         code_in[0] = cdsd_pkg::CODE_P;
         code_in[1] = cdsd_pkg::CODE_O;
         code_in[2] = cdsd_pkg::CODE_U;
         code_in[3] = cdsd_pkg::CODE_R;
      end else if (split_data.neg) begin
         code_in[0] = cdsd_pkg::CODE_DASH;
         code_in[1] = cdsd_pkg::CODE_DASH;
         code_in[2] = cdsd_pkg::CODE_DASH;
         code_in[3] = cdsd_pkg::CODE_DASH;
      end else begin
         code_in[0] = mt_mod[3:0];
         code_in[1] = mu_full[3:0];
         code_in[2] = {1'b0, st};
         code_in[3] = su_full[3:0];
      end
   end

   always_comb begin
      c_valid_in = c_valid_ff;
      c_idx_in   = c_idx_ff;
      if (split_take) begin
         c_valid_in = 1'b1;
         c_idx_in   = 2'd0;
      end else if (c_done) begin
         c_valid_in = 1'b0;
      end else if (c_fire) begin
         c_idx_in = c_idx_ff + 2'd1;
      end
      o_valid_in = out_free ? c_valid_ff : o_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         c_idx_ff   <= 2'd0;
         o_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         c_idx_ff   <= c_idx_in;
         o_valid_ff <= o_valid_in;
      end
      if (split_take) begin
         for (int i = 0; i < cdsd_pkg::DIGITS; i++) begin
            c_code_ff[i] <= code_in[i];
         end
         c_bar_ff <= split_data.bar;
      end
      if (c_fire) begin
         o_enable_ff <= 4'(4'd1 << c_idx_ff);
         o_seg_ff    <= cdsd_pkg::seg_lookup(c_code_ff[c_idx_ff]);
         o_dp_ff     <= (c_idx_ff == 2'd1);
         o_bar_ff    <= c_bar_ff;
         o_last_ff   <= (c_idx_ff == 2'd3);
      end
   end

   assign rsp_valid           = o_valid_ff;
   assign rsp_digit_enable    = o_enable_ff;
   assign rsp_segment_pattern = o_seg_ff;
   assign rsp_decimal_point   = o_dp_ff;
   assign rsp_led_bar         = o_bar_ff;
   assign rsp_last_frame      = o_last_ff;

endmodule

/* design/countdown_seven_segment_driver_unit.sv */
// Top level of the countdown seven-segment driver.
// Depends on cdsd_pkg, cdsd_split and cdsd_frame.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   time_seconds(14,s) duration_value(8)
//   rsp      out        rsp_valid/stall   digit_enable segment_pattern
//                                         decimal_point led_bar last_frame
//
// Each request yields four frames, one per cycle from the frame sequencer when
// rsp_stall is low; new requests are taken while earlier ones are still framed.
// The first frame appears after the input, split, sequencer and result registers.
// Reset is synchronous and clears all valid flags.
// rsp_stall holds the result register; req_stall rises once the pipe backs up.
module countdown_seven_segment_driver_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [13:0] req_time_seconds,
   input  logic        [7:0]  req_duration_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_digit_enable,
   output logic [6:0]         rsp_segment_pattern,
   output logic               rsp_decimal_point,
   output logic [5:0]         rsp_led_bar,
   output logic               rsp_last_frame
);

   logic                split_valid;
   logic                split_take;
   cdsd_pkg::split_type split_data;

   cdsd_split u_split (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_time_seconds   (req_time_seconds),
      .req_duration_value (req_duration_value),
      .split_valid        (split_valid),
      .split_data         (split_data),
      .split_take         (split_take)
   );

   cdsd_frame u_frame (
      .clock               (clock),
      .reset               (reset),
      .split_valid         (split_valid),
      .split_data          (split_data),
      .split_take          (split_take),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_digit_enable    (rsp_digit_enable),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_decimal_point   (rsp_decimal_point),
      .rsp_led_bar         (rsp_led_bar),
      .rsp_last_frame      (rsp_last_frame)
   );

`ifndef SYNTHESIS
   // frames of one request follow without a gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_frame |=> rsp_valid)
      else $error("frame gap inside a request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_frame |=>
         rsp_digit_enable == 4'($past(rsp_digit_enable) << 1))
      else $error("digit select did not advance");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_frame |=>
         rsp_led_bar == $past(rsp_led_bar))
      else $error("led bar changed within a request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_digit_enable) &&
         (rsp_last_frame == rsp_digit_enable[3]) &&
         (rsp_decimal_point == rsp_digit_enable[1]))
      else $error("frame flags disagree with digit select");
`endif

endmodule
